[rtl/pif_pkg.sv]
// Package for the printf integer formatter: state and conversion codes,
// character tables and argument masking. Has no dependencies.
package pif_pkg;

  localparam int LongBits  = 64;
  localparam int MaxField  = 60;
  localparam int NumDigits = 22;
  localparam int DigW      = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    CV_DEC   = 3'd0,
    CV_UNS   = 3'd1,
    CV_OCT   = 3'd2,
    CV_HEXL  = 3'd3,
    CV_HEXU  = 3'd4,
    CV_CHAR  = 3'd5,
    CV_PTR   = 3'd6,
    CV_OTHER = 3'd7
  } conv_e;

  localparam logic [1:0] LcInt  = 2'd0;
  localparam logic [1:0] LcLong = 2'd1;

  localparam int FlLeft  = 0;
  localparam int FlPlus  = 1;
  localparam int FlSpace = 2;
  localparam int FlAlt   = 3;
  localparam int FlZero  = 4;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChUpX     = 8'h58;

  // Map one digit value to its character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h37 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  // Characters of the null pointer text
  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6C;
      3'd4:    c = 8'h29;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

  // Significant bit count of the length class
  function automatic logic [6:0] class_bits(input logic [1:0] lc);
    logic [6:0] b;
    if (lc == LcInt) begin
      b = 7'd32;
    end else if (lc == LcLong) begin
      b = 7'(LongBits);
    end else begin
      b = 7'd64;
    end
    return b;
  endfunction

  function automatic logic [63:0] bits_mask(input logic [6:0] b);
    logic [63:0] m;
    if (b >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << b[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

[rtl/printf_integer_formatter_top.sv]
// Top level of the printf integer formatter: serial radix conversion and
// character emission. Depends on pif_pkg.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | mode .. digit_precision
//  out     | output    | out_valid_o / out_stall_i | out_char, last
//
// One item at a time. A conversion shifts the argument bit by bit into a
// 22-digit chain, drops leading zero digits one a cycle but keeps at least
// one, takes a setup step, then emits one character per cycle while the
// output does not stall (up to 62 characters); literals, character and
// unknown conversions skip the first two steps. Reset clears all control
// state. An output stall holds the current character; the input stays
// stalled until the last character of the item is registered.
module printf_integer_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [2:0]  conversion_i,
  input  logic [1:0]  length_class_i,
  input  logic [63:0] argument_i,
  input  logic [4:0]  flag_bits_i,
  input  logic [5:0]  field_width_i,
  input  logic signed [6:0] digit_precision_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  localparam int DigBits = pif_pkg::NumDigits * pif_pkg::DigW;

  pif_pkg::state_e state_q, state_d;

  // item fields
  logic        mode_q;
  logic [7:0]  lit_q;
  logic [2:0]  conv_q;
  logic [4:0]  flags_q;
  logic [5:0]  width_q;
  logic        prec_given_q;
  logic [5:0]  prec_q;
  logic [7:0]  argb_q;
  logic        neg_q;
  logic        vnz_q;
  logic [4:0]  base_q;

  // working registers
  logic [63:0]        v_q, v_d;
  logic [DigBits-1:0] dig_q, dig_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [4:0]         nd_q, nd_d;
  logic [5:0]         spre_q, spre_d, zw_q, zw_d, zp_q, zp_d, spost_q, spost_d;
  logic [1:0]         npfx_q, npfx_d;
  logic [7:0]         pfx0_q, pfx0_d, pfx1_q, pfx1_d;
  logic [2:0]         nil_q, nil_d;
  logic [6:0]         rem_q, rem_d;

  logic        ov_q, ov_d;
  logic [7:0]  och_q, och_d;
  logic        olast_q, olast_d;

  logic        accept;
  logic [63:0] in_v;
  logic        in_neg;
  logic [6:0]  in_bits;
  logic [63:0] in_mask;
  logic [DigBits-1:0] dig_step;

  assign in_stall_o  = (state_q != pif_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_char_o  = och_q;
  assign last_o      = olast_q;

  function automatic logic [6:0] class_bits_sel(input logic [2:0] cv, input logic [1:0] lc);
    logic [6:0] b;
    if (cv == pif_pkg::CV_PTR) begin
      b = 7'(pif_pkg::LongBits);
    end else begin
      b = pif_pkg::class_bits(lc);
    end
    return b;
  endfunction

  // Mask and take the magnitude of the argument
  always_comb begin
    logic [63:0] m;
    in_bits = class_bits_sel(conversion_i, length_class_i);
    in_mask = pif_pkg::bits_mask(in_bits);
    m       = argument_i & in_mask;
    in_neg  = (conversion_i == pif_pkg::CV_DEC) && m[in_bits[5:0] - 6'd1];
    in_v    = in_neg ? ((~m + 64'd1) & in_mask) : m;
  end

  // Shift one argument bit into the digit chain: each digit doubles, adds
  // the carry from below and wraps at the base
  always_comb begin
    logic       cin;
    logic [4:0] two;
    cin = v_q[63];
    for (int i = 0; i < pif_pkg::NumDigits; i++) begin
      two = {dig_q[i*pif_pkg::DigW +: pif_pkg::DigW], cin};
      if (two >= base_q) begin
        dig_step[i*pif_pkg::DigW +: pif_pkg::DigW] = 4'(two - base_q);
        cin = 1'b1;
      end else begin
        dig_step[i*pif_pkg::DigW +: pif_pkg::DigW] = two[3:0];
        cin = 1'b0;
      end
    end
  end

  // Next state, setup arithmetic and character emission
  always_comb begin
    logic        left, zero, sp, alt, numeric, ndz, fire;
    logic [5:0]  ndeff, zpad, spad;
    logic [6:0]  body;
    logic [1:0]  np;
    logic [7:0]  p0, p1;
    logic [3:0]  top;
    state_d = state_q;
    v_d = v_q; dig_d = dig_q; cnt_d = cnt_q; nd_d = nd_q;
    spre_d = spre_q; zw_d = zw_q; zp_d = zp_q; spost_d = spost_q;
    npfx_d = npfx_q; pfx0_d = pfx0_q; pfx1_d = pfx1_q; nil_d = nil_q; rem_d = rem_q;
    ov_d = ov_q; och_d = och_q; olast_d = olast_q;
    left = flags_q[pif_pkg::FlLeft];
    zero = flags_q[pif_pkg::FlZero] && !left && !prec_given_q;
    alt  = flags_q[pif_pkg::FlAlt];
    top  = dig_q[DigBits-1 -: pif_pkg::DigW];
    numeric = (conv_q <= pif_pkg::CV_HEXU);
    ndeff = 6'd0; zpad = 6'd0; spad = 6'd0; body = 7'd0; np = 2'd0;
    p0 = 8'd0; p1 = 8'd0; ndz = 1'b0; sp = 1'b0;
    fire = 1'b0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      pif_pkg::ST_IDLE: begin
        if (accept) begin
          v_d   = in_v;
          dig_d = '0;
          cnt_d = '1;
          nd_d  = 5'(pif_pkg::NumDigits);
          if (mode_i && (conversion_i <= pif_pkg::CV_HEXU ||
                         conversion_i == pif_pkg::CV_PTR)) begin
            state_d = pif_pkg::ST_CONV;
          end else begin
            state_d = pif_pkg::ST_SETUP;
          end
        end
      end
      pif_pkg::ST_CONV: begin
        dig_d = dig_step;
        v_d   = {v_q[62:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          state_d = pif_pkg::ST_NORM;
        end
      end
      pif_pkg::ST_NORM: begin
        // drop one leading zero digit a cycle, keep at least one
        if (nd_q > 5'd1 && top == 4'd0) begin
          dig_d = {dig_q[DigBits-pif_pkg::DigW-1:0], {pif_pkg::DigW{1'b0}}};
          nd_d  = nd_q - 5'd1;
        end else begin
          state_d = pif_pkg::ST_SETUP;
        end
      end
      pif_pkg::ST_SETUP: begin
        nil_d = 3'd0;
        if (!mode_q) begin
          np = 2'd1; p0 = lit_q; body = 7'd1;
        end else if (numeric) begin
          ndz   = prec_given_q && prec_q == 6'd0 && !vnz_q;
          ndeff = ndz ? 6'd0 : {1'b0, nd_q};
          zpad  = (prec_given_q && prec_q > ndeff) ? prec_q - ndeff : 6'd0;
          sp    = flags_q[pif_pkg::FlSpace] && !flags_q[pif_pkg::FlPlus];
          if (conv_q == pif_pkg::CV_DEC && (neg_q || flags_q[pif_pkg::FlPlus] || sp)) begin
            np = 2'd1;
            p0 = neg_q ? pif_pkg::ChMinus :
                 flags_q[pif_pkg::FlPlus] ? pif_pkg::ChPlus : pif_pkg::ChSpace;
          end
          if (alt && conv_q == pif_pkg::CV_OCT && zpad == 6'd0 &&
              (ndeff == 6'd0 || top != 4'd0)) begin
            np = 2'd1; p0 = pif_pkg::ChZero;
          end
          if (alt && (conv_q == pif_pkg::CV_HEXL || conv_q == pif_pkg::CV_HEXU) && vnz_q) begin
            np = 2'd2; p0 = pif_pkg::ChZero;
            p1 = (conv_q == pif_pkg::CV_HEXU) ? pif_pkg::ChUpX : pif_pkg::ChLowX;
          end
          body = 7'(np) + 7'(zpad) + 7'(ndeff);
        end else if (conv_q == pif_pkg::CV_CHAR) begin
          np = 2'd1; p0 = argb_q; body = 7'd1; zero = 1'b0;
        end else if (conv_q == pif_pkg::CV_PTR) begin
          zero = 1'b0;
          if (vnz_q) begin
            np = 2'd2; p0 = pif_pkg::ChZero; p1 = pif_pkg::ChLowX;
            ndeff = {1'b0, nd_q};
            body = 7'd2 + 7'(ndeff);
          end else begin
            nil_d = 3'd5; body = 7'd5;
          end
        end else begin
          np = (lit_q != 8'd0) ? 2'd2 : 2'd1;
          p0 = pif_pkg::ChPercent; p1 = lit_q; body = 7'(np);
        end
        if (mode_q && conv_q != pif_pkg::CV_OTHER && {1'b0, width_q} > body) begin
          spad = 6'({1'b0, width_q} - body);
        end
        spre_d  = (!left && !zero) ? spad : 6'd0;
        zw_d    = (!left && zero) ? spad : 6'd0;
        spost_d = left ? spad : 6'd0;
        zp_d    = zpad;
        nd_d    = ndeff[4:0];
        npfx_d  = np; pfx0_d = p0; pfx1_d = p1;
        rem_d   = body + 7'(spad);
        if (body + 7'(spad) == 7'd0) begin
          state_d = pif_pkg::ST_IDLE;
        end else begin
          state_d = pif_pkg::ST_EMIT;
        end
      end
      pif_pkg::ST_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          fire = 1'b1;
          ov_d = 1'b1;
          olast_d = (rem_q == 7'd1);
          rem_d = rem_q - 7'd1;
          if (rem_q == 7'd1) begin
            state_d = pif_pkg::ST_IDLE;
          end
          priority if (spre_q != 6'd0) begin
            och_d = pif_pkg::ChSpace; spre_d = spre_q - 6'd1;
          end else if (npfx_q != 2'd0) begin
            och_d = pfx0_q; pfx0_d = pfx1_q; npfx_d = npfx_q - 2'd1;
          end else if (nil_q != 3'd0) begin
            och_d = pif_pkg::nil_char(3'd5 - nil_q); nil_d = nil_q - 3'd1;
          end else if (zw_q != 6'd0) begin
            och_d = pif_pkg::ChZero; zw_d = zw_q - 6'd1;
          end else if (zp_q != 6'd0) begin
            och_d = pif_pkg::ChZero; zp_d = zp_q - 6'd1;
          end else if (nd_q != 5'd0) begin
            och_d = pif_pkg::digit_char(top, conv_q == pif_pkg::CV_HEXU);
            dig_d = {dig_q[DigBits-pif_pkg::DigW-1:0], {pif_pkg::DigW{1'b0}}};
            nd_d  = nd_q - 5'd1;
          end else begin
            och_d = pif_pkg::ChSpace; spost_d = spost_q - 6'd1;
          end
        end
      end
      default: state_d = pif_pkg::ST_IDLE;
    endcase
    if (!fire && ov_q && out_stall_i) begin
      ov_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pif_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Capture the item and hold the working data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      lit_q        <= literal_byte_i;
      conv_q       <= conversion_i;
      flags_q      <= flag_bits_i;
      width_q      <= (field_width_i > 6'(pif_pkg::MaxField)) ?
                      6'(pif_pkg::MaxField) : field_width_i;
      prec_given_q <= !digit_precision_i[6];
      prec_q       <= (digit_precision_i[5:0] > 6'(pif_pkg::MaxField)) ?
                      6'(pif_pkg::MaxField) : digit_precision_i[5:0];
      argb_q       <= argument_i[7:0];
      neg_q        <= in_neg;
      vnz_q        <= (in_v != 64'd0);
      base_q       <= (conversion_i == pif_pkg::CV_OCT) ? 5'd8 :
                      (conversion_i <= pif_pkg::CV_UNS) ? 5'd10 : 5'd16;
    end
    v_q     <= v_d;
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    nd_q    <= nd_d;
    spre_q  <= spre_d;
    zw_q    <= zw_d;
    zp_q    <= zp_d;
    spost_q <= spost_d;
    npfx_q  <= npfx_d;
    pfx0_q  <= pfx0_d;
    pfx1_q  <= pfx1_d;
    nil_q   <= nil_d;
    rem_q   <= rem_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for printf_integer_formatter_top: a queued driver and
// a monitor compare every character against an in-bench formatter. Uses pif_pkg.
module testbench;

  typedef struct {
    logic        mode;
    logic [7:0]  lit;
    pif_pkg::conv_e conv;
    logic [1:0]  lc;
    logic [63:0] arg;
    logic [4:0]  flags;
    logic [5:0]  width;
    logic [6:0]  prec;
  } fmt_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [7:0] literal_byte_i = '0;
  logic [2:0] conversion_i = '0;
  logic [1:0] length_class_i = '0;
  logic [63:0] argument_i = '0;
  logic [4:0] flag_bits_i = '0;
  logic [5:0] field_width_i = '0;
  logic signed [6:0] digit_precision_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic last_o;

  fmt_item_t pending_q[$];
  char_t     text_q[$];
  int        send_idle_pct = 8;
  int        recv_idle_pct = 57;
  int        hold_off = 0;
  bit        hold_fired = 1'b0;
  int        mismatches = 0;
  int        chars_seen = 0;
  int        items_sent = 0;
  longint    cycles = 0;
  bit        stim_done = 1'b0;

  printf_integer_formatter_top u_top (.*);

  always #1 clk_i = ~clk_i;

  // Append the expected text of one item
  function automatic void format_item(input fmt_item_t it);
    char_t      t[$];
    logic [7:0] digs[$];
    logic [7:0] pfx[$];
    logic [63:0] v, msk;
    int bits, w, p, nd, zpad, spad, base;
    logic left, plus, space, alt, zero;
    logic [7:0] sgn;
    if (!it.mode) begin
      text_q.push_back('{it.lit, 1'b1});
      return;
    end
    left = it.flags[pif_pkg::FlLeft];  plus = it.flags[pif_pkg::FlPlus];
    space = it.flags[pif_pkg::FlSpace] && !plus;
    alt = it.flags[pif_pkg::FlAlt];    zero = it.flags[pif_pkg::FlZero] && !left;
    w = (it.width > pif_pkg::MaxField) ? pif_pkg::MaxField : int'(it.width);
    p = it.prec[6] ? -1 : int'(it.prec);
    if (p > pif_pkg::MaxField) p = pif_pkg::MaxField;
    bits = (it.lc == 2'd0) ? 32 : (it.lc == 2'd1) ? pif_pkg::LongBits : 64;
    msk = (bits >= 64) ? '1 : ((64'd1 << bits) - 1);
    sgn = 8'h00;
    if (it.conv <= pif_pkg::CV_HEXU) begin
      v = it.arg & msk;
      base = (it.conv == pif_pkg::CV_OCT) ? 8 : (it.conv <= pif_pkg::CV_UNS) ? 10 : 16;
      if (it.conv == pif_pkg::CV_DEC) begin
        if (v[bits-1]) begin
          v = (~v + 1) & msk;
          sgn = "-";
        end else if (plus) sgn = "+";
        else if (space) sgn = " ";
      end
      begin
        logic [63:0] r;
        r = v;
        do begin
          digs.push_front((r % base) < 10 ? 8'(48 + r % base) :
                          8'((it.conv == pif_pkg::CV_HEXU ? 55 : 87) + r % base));
          r = r / base;
        end while (r != 0);
      end
      if (p == 0 && v == 0) digs.delete();
      nd = digs.size();
      if (p >= 0) zero = 1'b0;
      zpad = (p > nd) ? p - nd : 0;
      if (sgn != 8'h00) pfx.push_back(sgn);
      if (alt && it.conv == pif_pkg::CV_OCT && zpad == 0 && (nd == 0 || digs[0] != "0"))
        pfx.push_back("0");
      if (alt && (it.conv == pif_pkg::CV_HEXL || it.conv == pif_pkg::CV_HEXU) &&
          v != 0) begin
        pfx.push_back("0");
        pfx.push_back(it.conv == pif_pkg::CV_HEXU ? "X" : "x");
      end
      spad = w - (pfx.size() + zpad + nd);
      if (spad < 0) spad = 0;
      if (!left && !zero) repeat (spad) t.push_back('{" ", 1'b0});
      foreach (pfx[i]) t.push_back('{pfx[i], 1'b0});
      if (!left && zero) repeat (spad) t.push_back('{"0", 1'b0});
      repeat (zpad) t.push_back('{"0", 1'b0});
      foreach (digs[i]) t.push_back('{digs[i], 1'b0});
      if (left) repeat (spad) t.push_back('{" ", 1'b0});
    end else if (it.conv == pif_pkg::CV_CHAR) begin
      spad = (w > 1) ? w - 1 : 0;
      if (!left) repeat (spad) t.push_back('{" ", 1'b0});
      t.push_back('{it.arg[7:0], 1'b0});
      if (left) repeat (spad) t.push_back('{" ", 1'b0});
    end else if (it.conv == pif_pkg::CV_PTR) begin
      v = it.arg & ((pif_pkg::LongBits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                    ((64'd1 << pif_pkg::LongBits) - 1));
      if (v == 0) begin
        pfx = '{"(", "n", "i", "l", ")"};
      end else begin
        pfx = '{"0", "x"};
        while (v != 0) begin
          digs.push_front(v[3:0] < 10 ? 8'(48 + v[3:0]) : 8'(87 + v[3:0]));
          v = v >> 4;
        end
        foreach (digs[i]) pfx.push_back(digs[i]);
      end
      spad = (w > pfx.size()) ? w - pfx.size() : 0;
      if (!left) repeat (spad) t.push_back('{" ", 1'b0});
      foreach (pfx[i]) t.push_back('{pfx[i], 1'b0});
      if (left) repeat (spad) t.push_back('{" ", 1'b0});
    end else begin
      t.push_back('{"%", 1'b0});
      if (it.lit != 0) t.push_back('{it.lit, 1'b0});
    end
    if (t.size() > 64) t = t[0:63];
    if (t.size() > 0) t[t.size()-1].last = 1'b1;
    foreach (t[i]) text_q.push_back(t[i]);
  endfunction

  function automatic fmt_item_t conv_item(input pif_pkg::conv_e c, input logic [63:0] a,
                                          input logic [4:0] f, input int w,
                                          input int p, input logic [1:0] lc);
    fmt_item_t it;
    it.mode = 1'b1; it.lit = 8'h00; it.conv = c; it.lc = lc; it.arg = a;
    it.flags = f; it.width = 6'(w); it.prec = 7'(p);
    return it;
  endfunction

  function automatic fmt_item_t rand_item();
    fmt_item_t it;
    logic [63:0] a;
    it.mode = ($urandom_range(0, 9) != 0);
    it.lit = 8'($urandom);
    it.conv = pif_pkg::conv_e'($urandom_range(0, 7));
    it.lc = 2'($urandom);
    a = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: a = 64'($urandom_range(0, 20));
      1: a = a >> $urandom_range(0, 63);
      2: a = -(a >> $urandom_range(0, 63));
      default: ;
    endcase
    it.arg = a;
    it.flags = 5'($urandom);
    // keep most widths small so the run stays quick
    it.width = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    case ($urandom_range(0, 5))
      0: it.prec = 7'($urandom);
      1, 2: it.prec = 7'($urandom_range(0, 12));
      default: it.prec = 7'h7F;
    endcase
    return it;
  endfunction

  // Fill the queue of pending items
  initial begin
    fmt_item_t it;
    it = conv_item(pif_pkg::CV_DEC, 0, 0, 0, -1, 0);
    it.mode = 1'b0; it.lit = 8'h00; pending_q.push_back(it);
    it.lit = 8'hFF; pending_q.push_back(it);
    pending_q.push_back(conv_item(pif_pkg::CV_DEC, 64'h8000_0000, 5'h16, 12, -1, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_DEC, 64'h8000_0000_0000_0000, 5'h02,
                                  0, -1, 2));
    pending_q.push_back(conv_item(pif_pkg::CV_DEC, 64'd42, 5'h14, 8, -1, 1));
    pending_q.push_back(conv_item(pif_pkg::CV_DEC, 64'd42, 5'h1D, 8, 5, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_DEC, 0, 5'h00, 0, 0, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_UNS, '1, 5'h10, 63, 127, 3));
    pending_q.push_back(conv_item(pif_pkg::CV_UNS, '1, 5'h00, 0, 63, 2));
    pending_q.push_back(conv_item(pif_pkg::CV_OCT, 0, 5'h08, 0, 0, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_OCT, 64'o17, 5'h08, 6, -1, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_OCT, 64'o17, 5'h08, 0, 4, 2));
    pending_q.push_back(conv_item(pif_pkg::CV_HEXL, 64'hDEAD_BEEF, 5'h18, 14, -1, 2));
    pending_q.push_back(conv_item(pif_pkg::CV_HEXU, 0, 5'h08, 4, -1, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_HEXU, '1, 5'h09, 20, -1, 2));
    pending_q.push_back(conv_item(pif_pkg::CV_CHAR, 64'h141, 5'h1F, 5, 3, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_CHAR, 64'h00, 5'h00, 60, -1, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_PTR, 0, 5'h10, 9, 4, 0));
    pending_q.push_back(conv_item(pif_pkg::CV_PTR, 64'hFF00_0000_0000_1234, 5'h01,
                                  25, -1, 0));
    it = conv_item(pif_pkg::CV_OTHER, 0, 5'h1F, 10, 5, 0); pending_q.push_back(it);
    it.lit = "q"; pending_q.push_back(it);
    repeat (360) pending_q.push_back(rand_item());
  end

  // Drive transactions, holding the payload while stalled
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) items_sent <= items_sent + 1;
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        fmt_item_t it;
        it = pending_q.pop_front();
        format_item(it);
        in_valid_i <= 1'b1;
        mode_i <= it.mode; literal_byte_i <= it.lit; conversion_i <= it.conv;
        length_class_i <= it.lc; argument_i <= it.arg; flag_bits_i <= it.flags;
        field_width_i <= it.width; digit_precision_i <= it.prec;
      end else begin
        in_valid_i <= 1'b0;
        if (pending_q.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // Check each character transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        chars_seen <= chars_seen + 1;
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected char %h last %b", out_char_o, last_o);
        end else begin
          char_t e;
          e = text_q.pop_front();
          if (e.ch !== out_char_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b got %h/%b", e.ch, e.last,
                       out_char_o, last_o);
          end
        end
      end
      out_stall_i <= (hold_off > 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off to back up the input, once per run
  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
    else if (items_sent == 60 && !hold_fired) begin
      hold_off <= 600;
      hold_fired <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (items_sent == 130) begin
      send_idle_pct <= 57; recv_idle_pct <= 8;
    end else if (items_sent == 260) begin
      send_idle_pct <= 0; recv_idle_pct <= 0;
    end
    if (cycles > 1000000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !in_valid_i && text_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d items (literals, all conversions, flags, widths) and %0d chars.",
             items_sent, chars_seen);
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
